FILE: hdl/bta_pkg.sv
// shared types and constants for the buddy tile allocator
package bta_pkg;

	localparam logic [1:0] TAG_NONE = 2'b00;
	localparam logic [1:0] TAG_USED = 2'b01;
	localparam logic [1:0] TAG_FREE = 2'b10;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_SCAN,
		ST_A_RD,
		ST_A_UNL_W,
		ST_A_SPLIT,
		ST_A_PUSH_RD,
		ST_A_PUSH_W,
		ST_A_DONE,
		ST_F_RD,
		ST_F_CHK,
		ST_F_BRD,
		ST_F_BCHK,
		ST_F_UNL_W,
		ST_F_PUSH_RD,
		ST_F_PUSH_W,
		ST_OUT
	} state_t;

endpackage

FILE: hdl/buddy_tile_allocator.sv
// buddy tile allocator top level
// Buddy allocator over 2**LOG_TILES tiles. One request (kind, order, tile_index) is taken
// at a time and gives one result (granted_tile, success). After reset a clearing pass
// sweeps every entry of the tag and link memories; no request is taken meanwhile.
// Every step goes through the single port of the link/tag memory, and each link fix-up
// of a list neighbor is a read then a write. The free list scan walks one order per
// cycle. An allocate goes through the scan, the head read, the unlink write and its
// fix-up, a split check and a push write with its fix-up per split, then the last
// split check and the result. A free that merges all the way up goes through the
// read and check of the block, then per merge a buddy read, a buddy check, an unlink
// write and the fix-ups of its list neighbors, then the push and the result. Free lists
// are doubly linked; heads sit in flip-flops. The result waits in an output register
// until taken, and no new request is taken meanwhile.
module buddy_tile_allocator #(
	parameter int LOG_TILES = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [3:0] order,
	input  logic [9:0] tile_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [9:0] granted_tile,
	output logic       success
);
	import bta_pkg::*;

	localparam int NT = 1 << LOG_TILES;
	localparam int AW = LOG_TILES;
	localparam int LW = LOG_TILES + 1;
	localparam int OW = 4;
	localparam int EW = 2 * LW + 2 + OW; // next, prev, tag, order
	localparam logic [LW-1:0] NIL = LW'(NT);
	localparam logic [OW-1:0] TOP = OW'(LOG_TILES);

	typedef struct packed {
		logic [LW-1:0] nxt;
		logic [LW-1:0] prv;
		logic [1:0]    tag;
		logic [OW-1:0] ord;
	} ent_t;

	state_t state_q, state_d;
	logic [LW-1:0] head_q [LOG_TILES+1];
	logic [AW:0]   clr_q;
	logic [OW-1:0] req_q, ord_q;
	logic [AW-1:0] t_q, b_q;
	ent_t          e_q;
	logic [9:0]    gnt_q;
	logic          ok_q, ovld_q;

	// memory port: one entry per tile, plus a fix-up of a neighbor's link
	logic          we;
	logic [AW-1:0] addr;
	ent_t          wdat, rdat;
	bta_ram #(.WIDTH(EW), .DEPTH(NT)) u_ent (
		.clk(clk), .we(we), .addr(addr), .wdata(wdat), .rdata(rdat)
	);

	// link fix-ups are queued and drained one at a time; the state machine waits while any are queued
	logic [1:0]    fix_cnt_q;
	logic [AW-1:0] fix_a_q [2];
	logic          fix_isnext_q [2];
	logic [LW-1:0] fix_v_q [2];
	logic          fix_rd_q;
	// fix-ups need read-modify-write: read in fix_rd_q=0, write next

	assign in_stall  = (state_q != ST_IDLE) || ovld_q;
	assign out_valid = ovld_q;
	assign granted_tile = gnt_q;
	assign success   = ok_q;

	logic [AW-1:0] push_t;
	assign push_t = t_q | AW'((AW+1)'(1) << ord_q);

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		addr = t_q;
		wdat = '{nxt: NIL, prv: NIL, tag: TAG_NONE, ord: '0};
		if (fix_cnt_q != 2'd0) begin
			addr = fix_a_q[0];
			if (fix_rd_q) begin
				we = 1'b1;
				wdat = rdat;
				if (fix_isnext_q[0]) wdat.nxt = fix_v_q[0];
				else wdat.prv = fix_v_q[0];
			end
		end else begin
			case (state_q)
			ST_INIT: begin
				addr = clr_q[AW-1:0];
				we = 1'b1;
				if (clr_q[AW-1:0] == '0) begin
					wdat.tag = TAG_FREE;
					wdat.ord = TOP;
				end
				if (clr_q == (AW+1)'(NT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid && !ovld_q) begin
					if (kind == KIND_ALLOC) state_d = ST_A_SCAN;
					else if ((tile_index >> AW) != 10'd0) state_d = ST_OUT;
					else state_d = ST_F_RD;
				end
			end
			ST_A_SCAN: begin
				if (ord_q > TOP) state_d = ST_OUT;
				else if (head_q[ord_q] != NIL) state_d = ST_A_RD;
			end
			ST_A_RD: begin
				addr = t_q;
				state_d = ST_A_UNL_W;
			end
			ST_A_UNL_W: begin
				addr = t_q;
				we = 1'b1;
				wdat.tag = TAG_USED;
				wdat.ord = req_q;
				state_d = ST_A_SPLIT;
			end
			ST_A_SPLIT: begin
				if (ord_q == req_q) state_d = ST_OUT;
				else state_d = ST_A_PUSH_W;
			end
			ST_A_PUSH_W: begin
				addr = push_t;
				we = 1'b1;
				wdat.nxt = head_q[ord_q];
				wdat.tag = TAG_FREE;
				wdat.ord = ord_q;
				state_d = ST_A_SPLIT;
			end
			ST_F_RD: begin
				addr = t_q;
				state_d = ST_F_CHK;
			end
			ST_F_CHK: begin
				addr = t_q;
				if (rdat.tag != TAG_USED) state_d = ST_OUT;
				else begin
					// the freed start loses its tag before any merge
					we = 1'b1;
					state_d = ST_F_BRD;
				end
			end
			ST_F_BRD: begin
				if (ord_q >= TOP) state_d = ST_F_PUSH_W;
				else begin
					addr = b_q;
					state_d = ST_F_BCHK;
				end
			end
			ST_F_BCHK: begin
				addr = b_q;
				if (rdat.tag == TAG_FREE && rdat.ord == ord_q) state_d = ST_F_UNL_W;
				else state_d = ST_F_PUSH_W;
			end
			ST_F_UNL_W: begin
				addr = b_q;
				we = 1'b1;
				state_d = ST_F_BRD;
			end
			ST_F_PUSH_W: begin
				addr = t_q;
				we = 1'b1;
				wdat.nxt = head_q[ord_q];
				wdat.tag = TAG_FREE;
				wdat.ord = ord_q;
				state_d = ST_OUT;
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
			endcase
		end
	end

	// state, list heads and fix-up queue; an unlink of entry e at order o fixes neighbors and head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			clr_q <= '0;
			ovld_q <= 1'b0;
			fix_cnt_q <= '0;
			fix_rd_q <= 1'b0;
			for (int i = 0; i <= LOG_TILES; i++) begin
				head_q[i] <= (i == LOG_TILES) ? '0 : NIL;
			end
		end else begin
			state_q <= state_d;
			if (ovld_q && !out_stall) ovld_q <= 1'b0;
			if (fix_cnt_q != 2'd0) begin
				fix_rd_q <= !fix_rd_q;
				if (fix_rd_q) begin
					fix_cnt_q <= fix_cnt_q - 2'd1;
					fix_a_q[0] <= fix_a_q[1];
					fix_isnext_q[0] <= fix_isnext_q[1];
					fix_v_q[0] <= fix_v_q[1];
				end
			end else begin
				case (state_q)
				ST_INIT: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					if (in_valid && !ovld_q) begin
						req_q <= order;
						ord_q <= order;
						ok_q <= 1'b0;
						gnt_q <= '0;
						t_q <= AW'(tile_index);
					end
				end
				ST_A_SCAN: begin
					if (ord_q <= TOP) begin
						if (head_q[ord_q] == NIL) ord_q <= ord_q + 1'b1;
						else t_q <= head_q[ord_q][AW-1:0];
					end
				end
				ST_A_UNL_W: begin
					// rdat holds the head entry; it has no prev
					head_q[ord_q] <= rdat.nxt;
					if (rdat.nxt != NIL) begin
						fix_cnt_q <= 2'd1;
						fix_a_q[0] <= rdat.nxt[AW-1:0];
						fix_isnext_q[0] <= 1'b0;
						fix_v_q[0] <= NIL;
					end
					gnt_q <= 10'(t_q);
					ok_q <= 1'b1;
				end
				ST_A_SPLIT: begin
					if (ord_q != req_q) ord_q <= ord_q - 1'b1;
				end
				ST_A_PUSH_W: begin
					head_q[ord_q] <= LW'(push_t);
					if (head_q[ord_q] != NIL) begin
						fix_cnt_q <= 2'd1;
						fix_a_q[0] <= head_q[ord_q][AW-1:0];
						fix_isnext_q[0] <= 1'b0;
						fix_v_q[0] <= LW'(push_t);
					end
				end
				ST_F_CHK: begin
					ord_q <= rdat.ord;
					b_q <= t_q ^ AW'((AW+1)'(1) << rdat.ord);
				end
				ST_F_BCHK: e_q <= rdat;
				ST_F_UNL_W: begin
					if (e_q.prv == NIL) head_q[ord_q] <= e_q.nxt;
					fix_cnt_q <= 2'((e_q.nxt != NIL) + (e_q.prv != NIL));
					if (e_q.nxt != NIL) begin
						fix_a_q[0] <= e_q.nxt[AW-1:0];
						fix_isnext_q[0] <= 1'b0;
						fix_v_q[0] <= e_q.prv;
						fix_a_q[1] <= e_q.prv[AW-1:0];
						fix_isnext_q[1] <= 1'b1;
						fix_v_q[1] <= e_q.nxt;
					end else begin
						fix_a_q[0] <= e_q.prv[AW-1:0];
						fix_isnext_q[0] <= 1'b1;
						fix_v_q[0] <= e_q.nxt;
					end
					t_q <= t_q & ~AW'((AW+1)'(1) << ord_q);
					b_q <= (t_q & ~AW'((AW+1)'(1) << ord_q))
						^ AW'((AW+1)'(1) << (ord_q + 1'b1));
					ord_q <= ord_q + 1'b1;
				end
				ST_F_PUSH_W: begin
					head_q[ord_q] <= LW'(t_q);
					ok_q <= 1'b1;
					if (head_q[ord_q] != NIL) begin
						fix_cnt_q <= 2'd1;
						fix_a_q[0] <= head_q[ord_q][AW-1:0];
						fix_isnext_q[0] <= 1'b0;
						fix_v_q[0] <= LW'(t_q);
					end
				end
				ST_OUT: ovld_q <= 1'b1;
				default: ;
				endcase
			end
		end
	end
endmodule

FILE: hdl/bta_ram.sv
// generic single-port ram with registered read
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: hdl/bta_check.sv
// port-level checker for the buddy tile allocator, bound to the top level
module bta_check (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [9:0] granted_tile,
	input logic       success
);
	// a held result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_tile) && $stable(success))
		else $error("result changed while stalled");

	// a failed request carries no tile
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> granted_tile == 10'd0)
		else $error("tile on failed request");

	// no request taken while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken with result pending");

	// a request is never answered in the cycle after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result too early");
endmodule

bind buddy_tile_allocator bta_check u_bta_check (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.granted_tile(granted_tile), .success(success)
);
